>>> rtl/hsfd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and CRC-8 function of the humidity sensor frame decoder.
// No dependencies.
package hsfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam int unsigned TEMP_SPAN   = 17500;
    localparam int unsigned HUM_SPAN    = 10000;
    localparam int unsigned ROUND_HALF  = 32767;
    localparam int unsigned FULL_SCALE  = 65535;
    localparam int unsigned TEMP_OFFSET = 4500;

    localparam int TEMP_PROD_W = 31;
    localparam int HUM_PROD_W  = 30;

    typedef logic        [7:0]  t_byte;
    typedef logic        [15:0] t_raw;
    typedef logic signed [14:0] t_temp;
    typedef logic        [13:0] t_hum;

    typedef struct packed {
        logic good;
        t_raw temperature_raw;
        t_raw humidity_raw;
    } t_word;

    function automatic t_byte crc8_byte(input t_byte crc, input t_byte b);
        t_byte c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/hsfd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame bytes and decoded results.
// Depends on hsfd_pkg.
interface hsfd_in_if;
    logic          valid;
    logic          ready;
    hsfd_pkg::t_byte byte_value;
    logic          frame_start;

    modport source (output valid, output byte_value, output frame_start, input ready);
    modport sink   (input valid, input byte_value, input frame_start, output ready);
endinterface

interface hsfd_out_if;
    logic            valid;
    logic            ready;
    logic            status;
    hsfd_pkg::t_temp temperature_centi;
    hsfd_pkg::t_hum  humidity_centi;

    modport source (output valid, output status, output temperature_centi,
                    output humidity_centi, input ready);
    modport sink   (input valid, input status, input temperature_centi,
                    input humidity_centi, output ready);
endinterface

>>> rtl/hsfd_frame.sv
`timescale 1ns / 1ps
// Frame tracker: byte position, running CRC-8, raw words and the word register.
// Depends on hsfd_pkg and hsfd_in_if.
module hsfd_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hsfd_in_if.sink         i_byte,
    output hsfd_pkg::t_word o_word,
    output logic            o_word_valid,
    input  logic            i_word_ready
);
    import hsfd_pkg::*;

    logic [2:0] r_pos, n_pos;
    t_byte      r_crc, n_crc;
    t_raw       r_t_raw, n_t_raw;
    t_raw       r_h_raw, n_h_raw;
    logic       r_first_good, n_first_good;
    logic       r_word_valid, n_word_valid;
    t_word      r_word, n_word;

    logic       accept;
    logic [2:0] pos;
    t_byte      b;

    assign i_byte.ready = !r_word_valid || i_word_ready;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.byte_value;
    assign pos          = (i_byte.frame_start || r_pos > POS_H_CRC) ? POS_T_MSB : r_pos;

    always_comb begin
        n_pos        = r_pos;
        n_crc        = r_crc;
        n_t_raw      = r_t_raw;
        n_h_raw      = r_h_raw;
        n_first_good = r_first_good;
        n_word       = r_word;
        n_word_valid = r_word_valid && !i_word_ready;
        if (accept) begin
            unique case (pos)
                POS_T_MSB: begin
                    n_t_raw = {b, 8'h00};
                    n_crc   = crc8_byte(CRC_INIT, b);
                    n_pos   = POS_T_LSB;
                end
                POS_T_LSB: begin
                    n_t_raw = {r_t_raw[15:8], b};
                    n_crc   = crc8_byte(r_crc, b);
                    n_pos   = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_first_good = (r_crc == b);
                    n_crc        = CRC_INIT;
                    n_pos        = POS_H_MSB;
                end
                POS_H_MSB: begin
                    n_h_raw = {b, 8'h00};
                    n_crc   = crc8_byte(r_crc, b);
                    n_pos   = POS_H_LSB;
                end
                POS_H_LSB: begin
                    n_h_raw = {r_h_raw[15:8], b};
                    n_crc   = crc8_byte(r_crc, b);
                    n_pos   = POS_H_CRC;
                end
                POS_H_CRC: begin
                    n_word.good            = r_first_good && (r_crc == b);
                    n_word.temperature_raw = r_t_raw;
                    n_word.humidity_raw    = r_h_raw;
                    n_word_valid           = 1'b1;
                    n_crc                  = CRC_INIT;
                    n_pos                  = POS_T_MSB;
                end
                default: begin
                    n_pos = POS_T_MSB;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_T_MSB;
            r_crc        <= CRC_INIT;
            r_t_raw      <= '0;
            r_h_raw      <= '0;
            r_first_good <= 1'b0;
            r_word_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_crc        <= n_crc;
            r_t_raw      <= n_t_raw;
            r_h_raw      <= n_h_raw;
            r_first_good <= n_first_good;
            r_word_valid <= n_word_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word       = r_word;
    assign o_word_valid = r_word_valid;

endmodule

>>> rtl/hsfd_convert.sv
`timescale 1ns / 1ps
// Conversion pipeline: scaling products, divide by full scale, result register.
// Depends on hsfd_pkg and hsfd_out_if.
module hsfd_convert (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hsfd_pkg::t_word i_word,
    input  logic            i_word_valid,
    output logic            o_word_ready,
    hsfd_out_if.source      o_result
);
    import hsfd_pkg::*;

    localparam logic [16:0] DIV_CMP = 17'(FULL_SCALE);

    logic                   r_s2_valid;
    logic                   r_s2_good;
    logic [TEMP_PROD_W-1:0] r_t_prod;
    logic [HUM_PROD_W-1:0]  r_h_prod;

    logic                   r_o_valid;
    logic                   r_o_status;
    t_temp                  r_o_temp;
    t_hum                   r_o_hum;

    logic                   out_free;
    logic                   s2_free;
    logic                   s1_adv;
    logic                   s2_adv;

    logic [TEMP_PROD_W-1:0] t_prod;
    logic [HUM_PROD_W-1:0]  h_prod;
    logic [14:0]            t_hi;
    logic [16:0]            t_rem;
    logic [14:0]            t_q;
    logic [15:0]            t_val;
    logic [13:0]            h_hi;
    logic [16:0]            h_rem;
    logic [13:0]            h_q;

    assign out_free     = !r_o_valid || o_result.ready;
    assign s2_free      = !r_s2_valid || out_free;
    assign s1_adv       = i_word_valid && s2_free;
    assign s2_adv       = r_s2_valid && out_free;
    assign o_word_ready = s2_free;

    assign t_prod = TEMP_PROD_W'(32'(i_word.temperature_raw) * 32'(TEMP_SPAN)
                                + 32'(ROUND_HALF));
    assign h_prod = HUM_PROD_W'(32'(i_word.humidity_raw) * 32'(HUM_SPAN)
                                + 32'(ROUND_HALF));

    always_comb begin
        t_hi  = r_t_prod[TEMP_PROD_W-1:16];
        t_rem = {1'b0, r_t_prod[15:0]} + 17'(t_hi);
        t_q   = t_hi + 15'(t_rem >= DIV_CMP);
        t_val = 16'(t_q) - 16'(TEMP_OFFSET);
        h_hi  = r_h_prod[HUM_PROD_W-1:16];
        h_rem = {1'b0, r_h_prod[15:0]} + 17'(h_hi);
        h_q   = h_hi + 14'(h_rem >= DIV_CMP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= i_word_valid;
            end
            if (out_free) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_good <= i_word.good;
            r_t_prod  <= t_prod;
            r_h_prod  <= h_prod;
        end
        if (s2_adv) begin
            r_o_status <= !r_s2_good;
            r_o_temp   <= r_s2_good ? t_temp'(t_val[14:0]) : '0;
            r_o_hum    <= r_s2_good ? h_q : '0;
        end
    end

    assign o_result.valid             = r_o_valid;
    assign o_result.status            = r_o_status;
    assign o_result.temperature_centi = r_o_temp;
    assign o_result.humidity_centi    = r_o_hum;

endmodule

>>> rtl/humidity_sensor_frame_decoder.sv
`timescale 1ns / 1ps
// Humidity sensor frame decoder top level.
// Depends on hsfd_pkg, hsfd_if, hsfd_frame and hsfd_convert.
//
// Usage:
//   i_byte takes one frame byte per item: temperature MSB, LSB, CRC, then
//   humidity MSB, LSB, CRC. frame_start high marks the item as byte 0 and
//   drops any partial frame; without it bytes continue the current frame.
//   o_result gives one item per completed frame: status (0 both CRC-8
//   checks good, 1 mismatch), temperature in 0.01 degC and humidity in
//   0.01 %RH, both zero on a mismatch.
//   Throughput: one byte per cycle, sustained, while o_result drains.
//   Path: a completed frame passes the word register, the product stage
//   and the result register, in that order, before o_result shows it.
//   Stall: with o_result.ready low the result holds; up to three frame
//   results queue in the pipeline stages, after which i_byte.ready drops
//   until the output drains.
//   Reset (i_rst_n low, synchronous): frame restarts at byte 0, running CRC
//   returns to 0xFF, all pending results are dropped.
module humidity_sensor_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsfd_in_if.sink    i_byte,
    hsfd_out_if.source o_result
);
    import hsfd_pkg::*;

    t_word word;
    logic  word_valid;
    logic  word_ready;

    hsfd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_word       (word),
        .o_word_valid (word_valid),
        .i_word_ready (word_ready)
    );

    hsfd_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (word),
        .i_word_valid (word_valid),
        .o_word_ready (word_ready),
        .o_result     (o_result)
    );

endmodule

>>> rtl/hsfd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the humidity sensor frame decoder, bound to the top level.
// Depends on hsfd_pkg.
module hsfd_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_ready,
    input  logic            i_status,
    input  hsfd_pkg::t_temp i_temp,
    input  hsfd_pkg::t_hum  i_hum
);
    import hsfd_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status) |-> (i_temp == '0 && i_hum == '0))
        else $error("error result carries nonzero values");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_status) |->
        (i_temp >= -15'sd4500 && i_temp <= 15'sd13000 && i_hum <= 14'd10000))
        else $error("converted value out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
        (i_valid && $stable(i_status) && $stable(i_temp) && $stable(i_hum)))
        else $error("stalled result changed");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_result.valid),
    .i_ready  (o_result.ready),
    .i_status (o_result.status),
    .i_temp   (o_result.temperature_centi),
    .i_hum    (o_result.humidity_centi)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for humidity_sensor_frame_decoder: directed frame table, then random frames.
// Depends on hsfd_pkg, hsfd_if and the decoder RTL; checks every result against a predictor.
module tb;
    import hsfd_pkg::*;

    typedef struct packed {
        logic  status;
        t_temp temp;
        t_hum  hum;
    } t_frame_result;

    typedef struct {
        t_byte         b;
        bit            start;
        bit            typed;
        t_frame_result want;
    } t_dir_row;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    localparam int CORRUPT_NONE = 0;
    localparam int CORRUPT_TEMP = 1;
    localparam int CORRUPT_HUM  = 2;

    localparam t_temp T_LOW  = -15'sd4500;
    localparam t_temp T_ZERO = 15'sd0;
    localparam t_temp T_HIGH = 15'sd13000;
    localparam t_hum  H_ZERO = 14'd0;
    localparam t_hum  H_HIGH = 14'd10000;

    localparam t_frame_result NO_RESULT = '0;

    localparam int DIR_ROWS       = 25;
    localparam int RANDOM_ITEMS   = 900;
    localparam int SEG_ITEMS      = 150;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hsfd_in_if  in_bus ();
    hsfd_out_if out_bus ();

    humidity_sensor_frame_decoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (in_bus),
        .o_result (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [2:0] frame_pos;
    t_byte      word_crc;
    t_raw       temp_word;
    t_raw       hum_word;
    logic       temp_crc_ok;

    t_frame_result predicted_frames [$];
    t_dir_row      directed_rows [DIR_ROWS];

    int items_sent   = 0;
    int bad_results  = 0;
    int idle_cycles  = 0;
    int tx_gap_max   = 5;
    int rx_stall_max = 5;
    bit rx_hold_req  = 1'b0;

    function automatic t_byte crc8_step(input t_byte crc, input t_byte data);
        t_byte r;
        logic  fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic bit decode_frame_byte(input t_byte b, input bit start,
                                             output t_frame_result res);
        logic [2:0]      pos;
        logic            ok;
        longint unsigned tq;
        longint unsigned hq;
        res = NO_RESULT;
        pos = (start || frame_pos > POS_H_CRC) ? POS_T_MSB : frame_pos;
        case (pos)
            POS_T_MSB: begin
                temp_word = {b, 8'h00};
                word_crc  = crc8_step(CRC_INIT, b);
                frame_pos = POS_T_LSB;
            end
            POS_T_LSB: begin
                temp_word[7:0] = b;
                word_crc       = crc8_step(word_crc, b);
                frame_pos      = POS_T_CRC;
            end
            POS_T_CRC: begin
                temp_crc_ok = (word_crc == b);
                word_crc    = CRC_INIT;
                frame_pos   = POS_H_MSB;
            end
            POS_H_MSB: begin
                hum_word  = {b, 8'h00};
                word_crc  = crc8_step(word_crc, b);
                frame_pos = POS_H_LSB;
            end
            POS_H_LSB: begin
                hum_word[7:0] = b;
                word_crc      = crc8_step(word_crc, b);
                frame_pos     = POS_H_CRC;
            end
            default: begin
                ok = temp_crc_ok && (word_crc == b);
                if (ok) begin
                    tq = (64'(TEMP_SPAN) * temp_word + ROUND_HALF) / FULL_SCALE;
                    hq = (64'(HUM_SPAN) * hum_word + ROUND_HALF) / FULL_SCALE;
                    res.status = STATUS_OK;
                    res.temp   = t_temp'(longint'(tq) - longint'(TEMP_OFFSET));
                    res.hum    = t_hum'(hq);
                end else begin
                    res.status = STATUS_CRC_ERR;
                end
                word_crc  = CRC_INIT;
                frame_pos = POS_T_MSB;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_raw pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return 16'h0000;
        end else if (sel == 1) begin
            return 16'hFFFF;
        end
        return t_raw'($urandom_range(0, 65535));
    endfunction

    task automatic send_byte(input t_byte b, input bit start, input bit typed,
                             input t_frame_result typed_want);
        t_frame_result res;
        bit            has_res;
        int            gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.byte_value  <= b;
        in_bus.frame_start <= start;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        items_sent++;
        has_res = decode_frame_byte(b, start, res);
        if (has_res) begin
            predicted_frames.push_back(typed ? typed_want : res);
        end
    endtask

    task automatic send_frame(input t_raw t, input t_raw h, input bit lead,
                              input int bad_word, input int nbytes);
        t_byte fb [6];
        fb[0] = t[15:8];
        fb[1] = t[7:0];
        fb[2] = crc8_step(crc8_step(CRC_INIT, fb[0]), fb[1]);
        fb[3] = h[15:8];
        fb[4] = h[7:0];
        fb[5] = crc8_step(crc8_step(CRC_INIT, fb[3]), fb[4]);
        if (bad_word == CORRUPT_TEMP) begin
            fb[2] ^= t_byte'($urandom_range(1, 255));
        end else if (bad_word == CORRUPT_HUM) begin
            fb[5] ^= t_byte'($urandom_range(1, 255));
        end
        for (int k = 0; k < nbytes; k++) begin
            send_byte(fb[k], (k == 0) && lead, 1'b0, NO_RESULT);
        end
    endtask

    // hold the input low and wait until every predicted result has drained
    task automatic pause_until_drained();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_frames.size() != 0) @(posedge i_clk);
    endtask

    initial begin : byte_source
        int seg;
        int seg_end;
        int pick;
        int corrupt;
        int n;
        bit lead;
        bit need_start;

        in_bus.valid       <= 1'b0;
        in_bus.byte_value  <= '0;
        in_bus.frame_start <= 1'b0;
        i_rst_n            <= 1'b0;

        frame_pos   = POS_T_MSB;
        word_crc    = CRC_INIT;
        temp_word   = '0;
        hum_word    = '0;
        temp_crc_ok = 1'b0;

        directed_rows = '{
            // free-running frame from reset, zero words
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h81, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h81, 1'b0, 1'b1, {STATUS_OK, T_LOW, H_ZERO}},
            // full-scale words behind a start flag
            '{8'hFF, 1'b1, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hAC, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hAC, 1'b0, 1'b1, {STATUS_OK, T_HIGH, H_HIGH}},
            // start flag drops the partial frame
            '{8'h55, 1'b1, 1'b0, NO_RESULT},
            '{8'hBE, 1'b1, 1'b0, NO_RESULT},
            '{8'hEF, 1'b0, 1'b0, NO_RESULT},
            '{8'h92, 1'b0, 1'b0, NO_RESULT},
            '{8'hBE, 1'b0, 1'b0, NO_RESULT},
            '{8'hEF, 1'b0, 1'b0, NO_RESULT},
            '{8'h92, 1'b0, 1'b0, NO_RESULT},
            // bad temperature CRC, zeroed values
            '{8'h00, 1'b1, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hAC, 1'b0, 1'b1, {STATUS_CRC_ERR, T_ZERO, H_ZERO}}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_byte(directed_rows[r].b, directed_rows[r].start,
                      directed_rows[r].typed, directed_rows[r].want);
        end

        seg        = 0;
        need_start = 1'b0;
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            pause_until_drained();
            case (seg % 3)
                0: begin
                    tx_gap_max   = 5;
                    rx_stall_max = 5;
                end
                1: begin
                    tx_gap_max   = 0;
                    rx_stall_max = 0;
                end
                default: begin
                    tx_gap_max   = 5 * $urandom_range(0, 1);
                    rx_stall_max = 5 * $urandom_range(0, 1);
                end
            endcase
            if (seg == 2) begin
                tx_gap_max  = 0;
                rx_hold_req = 1'b1;
            end
            seg_end = items_sent + SEG_ITEMS;
            while (items_sent < seg_end) begin
                pick = $urandom_range(0, 9);
                lead = need_start || ($urandom_range(0, 1) == 1);
                if (pick < 7) begin
                    corrupt = CORRUPT_NONE;
                    if ($urandom_range(0, 7) == 0) begin
                        corrupt = ($urandom_range(0, 1) == 0) ? CORRUPT_TEMP : CORRUPT_HUM;
                    end
                    send_frame(pick_word(), pick_word(), lead, corrupt, 6);
                    need_start = 1'b0;
                end else if (pick < 9) begin
                    send_frame(pick_word(), pick_word(), lead, CORRUPT_NONE,
                               $urandom_range(1, 5));
                    need_start = 1'b1;
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        send_byte(t_byte'($urandom_range(0, 255)),
                                  $urandom_range(0, 7) == 0, 1'b0, NO_RESULT);
                    end
                    need_start = 1'b1;
                end
            end
            seg++;
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_results == 0 && predicted_frames.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int            stall;
        t_frame_result got;
        t_frame_result want;

        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                out_bus.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_bus.valid) @(posedge i_clk);
            got = {out_bus.status, out_bus.temperature_centi, out_bus.humidity_centi};
            if (predicted_frames.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT) begin
                    $display("unexpected result: status %0d temp %0d hum %0d",
                             got.status, got.temp, got.hum);
                end
            end else begin
                want = predicted_frames.pop_front();
                if (got.status !== want.status || got.temp !== want.temp ||
                    got.hum !== want.hum) begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT) begin
                        $display("result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.status, want.temp, want.hum,
                                 got.status, got.temp, got.hum);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

>>> files.f
rtl/hsfd_pkg.sv
rtl/hsfd_if.sv
rtl/hsfd_frame.sv
rtl/hsfd_convert.sv
rtl/humidity_sensor_frame_decoder.sv
rtl/hsfd_checker.sv
tb/tb.sv
